@@ hdl/pfsd_pkg.sv @@
`timescale 1ns / 1ps

package pfsd_pkg;

   localparam int DEFAULT_PHASE_COUNT = 8;
   localparam int DEFAULT_FULL_SPEED  = 100;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_BAND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INT_LIMIT = 3'd5;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // The PID sum is scaled by 1/100; the quotient never needs more than eight bits.
   localparam int DIV_SCALE = 100;
   localparam int QUO_W = 8;
   localparam logic [13:0] DIV_SCALED = 14'(DIV_SCALE * 128);
   localparam logic [25:0] DIV_LIMIT = 26'(DIV_SCALE * 256);
   localparam logic [6:0] TICK_MAX = 7'd127;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PREP = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_CHK  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_POST = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   function automatic logic [3:0] coil_entry(input logic [2:0] idx);
      logic [3:0] pattern;
      case (idx)
         3'd0: pattern = 4'h2;
         3'd1: pattern = 4'h6;
         3'd2: pattern = 4'h4;
         3'd3: pattern = 4'hC;
         3'd4: pattern = 4'h8;
         3'd5: pattern = 4'h9;
         3'd6: pattern = 4'h1;
         3'd7: pattern = 4'h3;
         default: pattern = 4'h3;
      endcase
      return pattern;
   endfunction

endpackage

@@ hdl/pid_fan_stepper_drive_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Ports               Contents
// req       in         req_tvalid/tready   tdata: temperature; tuser: operation
// rsp       out        rsp_tvalid/tready   tdata: speed, coil pattern, stepped
// csr       in         csr_we/index/wdata  six control registers, write only
//
// A word is taken only while the sequencer is idle. A sample runs eight
// bit-serial multiply and eight restoring divide steps; a stopping sample or
// a tick at zero speed skips both, a sample whose sum is out of range skips
// the divide and any other tick skips the multiply. Reset is synchronous
// and loads the register defaults. A stalled result holds in the output
// register while the next word is accepted.

module pid_fan_stepper_drive_top #(
   parameter int PHASE_COUNT = pfsd_pkg::DEFAULT_PHASE_COUNT,
   parameter int FULL_SPEED  = pfsd_pkg::DEFAULT_FULL_SPEED
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [10:0] temperature_tenths, [15:11] zero
   input  logic [pfsd_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  logic [pfsd_pkg::REQ_USER_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [6:0] speed, [10:7] coil_pattern, [11] stepped, [15:12] zero
   output logic [pfsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic [pfsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pfsd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pfsd_pkg::*;

   localparam logic [7:0] FULL_SPEED_W = 8'(FULL_SPEED);
   localparam logic [3:0] PHASE_LIM = 4'(PHASE_COUNT);

   state_type state_ff, state_in;

   logic signed [11:0] target_ff, target_in;
   logic [3:0] dead_ff, dead_in;
   logic [7:0] gp_ff, gp_in, gi_ff, gi_in, gd_ff, gd_in;
   logic [10:0] ilim_ff, ilim_in;

   logic signed [11:0] acc_ff, acc_in;
   logic signed [13:0] prev_ff, prev_in;
   logic [6:0] fan_ff, fan_in;
   logic [6:0] tick_ff, tick_in;
   logic [2:0] phase_ff, phase_in;
   logic [3:0] coil_ff, coil_in;
   logic stepped_ff, stepped_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic op_ff, op_in;
   logic [10:0] temp_ff, temp_in;
   logic signed [17:0] tp_ff, tp_in, td_ff, td_in;
   logic signed [13:0] ti_ff, ti_in;
   logic [7:0] gps_ff, gps_in, gis_ff, gis_in, gds_ff, gds_in;
   logic [2:0] cnt_ff, cnt_in;
   logic signed [25:0] prod_ff, prod_in;
   logic [14:0] rem_ff, rem_in;
   logic [13:0] dsh_ff, dsh_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [13:0] err;
   logic signed [12:0] stop_lim;
   logic stop;
   logic signed [14:0] acc_sum, lim_pos;
   logic signed [11:0] acc_new;
   logic signed [13:0] diff, acc_w;
   logic signed [17:0] err_w, diff_w;
   logic signed [25:0] add_p, add_i, add_d;
   logic [8:0] thr_w;
   logic [6:0] thr, tick_next;
   logic [3:0] phase_inc;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      err = $signed({3'b000, temp_ff}) - {{2{target_ff[11]}}, target_ff};
      stop_lim = {target_ff[11], target_ff} + $signed({9'd0, dead_ff});
      stop = ($signed({2'b00, temp_ff}) <= stop_lim);
      acc_sum = {{3{acc_ff[11]}}, acc_ff} + {err[13], err};
      lim_pos = $signed({4'd0, ilim_ff});
      if (acc_sum > lim_pos) begin
         acc_new = lim_pos[11:0];
      end else if (acc_sum < -lim_pos) begin
         acc_new = 12'(-lim_pos);
      end else begin
         acc_new = acc_sum[11:0];
      end
      diff = err - prev_ff;
      err_w = {{4{err[13]}}, err};
      diff_w = {{4{diff[13]}}, diff};
      acc_w = {{2{acc_new[11]}}, acc_new};
      add_p = gps_ff[7] ? {{8{tp_ff[17]}}, tp_ff} : '0;
      add_d = gds_ff[7] ? {{8{td_ff[17]}}, td_ff} : '0;
      add_i = gis_ff[7] ? {{12{ti_ff[13]}}, ti_ff} : '0;
      thr_w = {1'b0, quo_ff} + 9'd1;
      thr = (thr_w > {2'b00, TICK_MAX}) ? TICK_MAX : thr_w[6:0];
      tick_next = (tick_ff != TICK_MAX) ? tick_ff + 7'd1 : tick_ff;
      phase_inc = {1'b0, phase_ff} + 4'd1;
   end

   always_comb begin
      state_in = state_ff;
      target_in = target_ff;
      dead_in = dead_ff;
      gp_in = gp_ff;
      gi_in = gi_ff;
      gd_in = gd_ff;
      ilim_in = ilim_ff;
      acc_in = acc_ff;
      prev_in = prev_ff;
      fan_in = fan_ff;
      tick_in = tick_ff;
      phase_in = phase_ff;
      coil_in = coil_ff;
      stepped_in = stepped_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in = op_ff;
      temp_in = temp_ff;
      tp_in = tp_ff;
      td_in = td_ff;
      ti_in = ti_ff;
      gps_in = gps_ff;
      gis_in = gis_ff;
      gds_in = gds_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      rsp_data_in = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_TARGET: target_in = csr_wdata;
            CSR_DEAD_BAND: dead_in = csr_wdata[3:0];
            CSR_GAIN_P: gp_in = csr_wdata[7:0];
            CSR_GAIN_I: gi_in = csr_wdata[7:0];
            CSR_GAIN_D: gd_in = csr_wdata[7:0];
            CSR_INT_LIMIT: ilim_in = csr_wdata[10:0];
            default: ;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tuser[0];
               temp_in = req_tdata[10:0];
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            stepped_in = 1'b0;
            if (op_ff == OP_SAMPLE) begin
               if (stop) begin
                  fan_in = 7'd0;
                  state_in = ST_FIN;
               end else begin
                  acc_in = acc_new;
                  prev_in = err;
                  tp_in = {err_w[14:0], 3'b000} + {err_w[16:0], 1'b0};
                  td_in = {diff_w[14:0], 3'b000} + {diff_w[16:0], 1'b0};
                  ti_in = {acc_w[12:0], 1'b0} + acc_w;
                  gps_in = gp_ff;
                  gis_in = gi_ff;
                  gds_in = gd_ff;
                  prod_in = '0;
                  cnt_in = 3'd7;
                  state_in = ST_MUL;
               end
            end else begin
               if (fan_ff == 7'd0) begin
                  coil_in = 4'd0;
                  tick_in = 7'd0;
                  state_in = ST_FIN;
               end else begin
                  rem_in = {7'd0, FULL_SPEED_W};
                  dsh_in = {fan_ff, 7'd0};
                  cnt_in = 3'd7;
                  state_in = ST_DIV;
               end
            end
         end
         ST_MUL: begin
            prod_in = {prod_ff[24:0], 1'b0} + add_p + add_d + add_i;
            gps_in = {gps_ff[6:0], 1'b0};
            gis_in = {gis_ff[6:0], 1'b0};
            gds_in = {gds_ff[6:0], 1'b0};
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (prod_ff[25]) begin
               fan_in = 7'd0;
               state_in = ST_FIN;
            end else if (prod_ff >= $signed(DIV_LIMIT)) begin
               fan_in = FULL_SPEED_W[6:0];
               state_in = ST_FIN;
            end else begin
               rem_in = prod_ff[14:0];
               dsh_in = DIV_SCALED;
               cnt_in = 3'd7;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ff >= {1'b0, dsh_ff}) begin
               rem_in = rem_ff - {1'b0, dsh_ff};
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            dsh_in = {1'b0, dsh_ff[13:1]};
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (op_ff == OP_SAMPLE) begin
               fan_in = (quo_ff > FULL_SPEED_W) ? FULL_SPEED_W[6:0] : quo_ff[6:0];
            end else if (tick_next >= thr) begin
               tick_in = 7'd0;
               phase_in = (phase_inc < PHASE_LIM) ? phase_inc[2:0] : 3'd0;
               coil_in = coil_entry((phase_inc < PHASE_LIM) ? phase_inc[2:0] : 3'd0);
               stepped_in = 1'b1;
            end else begin
               tick_in = tick_next;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = {4'd0, stepped_ff, coil_ff, fan_ff};
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         target_ff <= 12'sd250;
         dead_ff <= 4'd2;
         gp_ff <= 8'd20;
         gi_ff <= 8'd1;
         gd_ff <= 8'd3;
         ilim_ff <= 11'd1000;
         acc_ff <= '0;
         prev_ff <= '0;
         fan_ff <= '0;
         tick_ff <= '0;
         phase_ff <= '0;
         coil_ff <= 4'h3;
         stepped_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         target_ff <= target_in;
         dead_ff <= dead_in;
         gp_ff <= gp_in;
         gi_ff <= gi_in;
         gd_ff <= gd_in;
         ilim_ff <= ilim_in;
         acc_ff <= acc_in;
         prev_ff <= prev_in;
         fan_ff <= fan_in;
         tick_ff <= tick_in;
         phase_ff <= phase_in;
         coil_ff <= coil_in;
         stepped_ff <= stepped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      temp_ff <= temp_in;
      tp_ff <= tp_in;
      td_ff <= td_in;
      ti_ff <= ti_in;
      gps_ff <= gps_in;
      gis_ff <= gis_in;
      gds_ff <= gds_in;
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
